// ===== rtl/core/erf_pkg.sv =====
// ----------------------------------------------------------------------------
// erf_pkg
// Shared widths, codes and the token type of the ellipse region flagger.
// ----------------------------------------------------------------------------
package erf_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int COORD_W     = 20;
  localparam int RAD_W       = 15;
  localparam int LOC_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // registered stages inside a cell before its compare
  localparam int CELL_LAT    = 3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK    = 1'b1;

  localparam logic [CNT_W-1:0] REGION_COUNT_RST = '0;
  localparam logic [LOC_W-1:0] FLAG_MASK_RST    = LOC_W'(1);

  // item travelling down the cell chain; x/y hold the centre for a load
  // and the event position for a classify item
  typedef struct packed {
    logic                      vld;
    logic                      evt;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RAD_W-1:0]          rx;
    logic [RAD_W-1:0]          ry;
    logic [LOC_W-1:0]          loc;
    logic                      last;
  } tok_t;

endpackage

// ===== rtl/core/erf_evt_if.sv =====
// ----------------------------------------------------------------------------
// erf_evt_if
// Input channel: load and classify items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface erf_evt_if import erf_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [IDX_W-1:0]          region_index;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [RAD_W-1:0]          radius_x;
  logic [RAD_W-1:0]          radius_y;
  logic signed [COORD_W-1:0] event_x;
  logic signed [COORD_W-1:0] event_y;
  logic [LOC_W-1:0]          location_in;
  logic                      last_event;

  modport source (
    output valid, func, region_index, center_x, center_y, radius_x, radius_y,
           event_x, event_y, location_in, last_event,
    input  ready
  );

  modport sink (
    input  valid, func, region_index, center_x, center_y, radius_x, radius_y,
           event_x, event_y, location_in, last_event,
    output ready
  );

endinterface

// ===== rtl/core/erf_res_if.sv =====
// ----------------------------------------------------------------------------
// erf_res_if
// Output channel: one flagged location byte per classify item.
// ----------------------------------------------------------------------------
interface erf_res_if import erf_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [LOC_W-1:0] location_out;
  logic             hit;
  logic             last_out;

  modport source (
    output valid, location_out, hit, last_out,
    input  ready
  );

  modport sink (
    input  valid, location_out, hit, last_out,
    output ready
  );

endinterface

// ===== rtl/core/erf_cell.sv =====
// ----------------------------------------------------------------------------
// erf_cell
// One region slot: stores its ellipse, tests passing events, forwards items.
// ----------------------------------------------------------------------------
module erf_cell import erf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [IDX_W-1:0]        cell_id_i,
  input  logic [CNT_W-1:0]        region_count_i,
  input  tok_t                    tok_i,
  input  logic                    hit_i,
  output tok_t                    tok_o,
  output logic                    hit_o
);

  // slot contents; the semi-axes are kept unsquared, |d| < r is the same
  // test as d*d < r*r
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]          rx_q, ry_q;

  tok_t                      tok_q;

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic                      okx, oky, active, ld_hit;

  logic                      s1_live_q, s2_live_q, s3_live_q;
  logic [RAD_W-1:0]          s1_adx_q, s1_ady_q, s1_rx_q, s1_ry_q;
  logic [2*RAD_W-1:0]        s2_a_q, s2_b_q, s2_c_q;
  logic [4*RAD_W-1:0]        s3_a2_q, s3_b2_q, s3_c2_q;
  logic [4*RAD_W:0]          sum;
  logic                      in_ellipse;
  logic                      hit_q;

  assign ld_hit = tok_i.vld && (tok_i.evt == FUNC_LOAD) && (tok_i.idx == cell_id_i);
  assign active = {1'b0, cell_id_i} < region_count_i;

  always_comb begin
    dx  = (COORD_W+1)'(tok_i.x) - (COORD_W+1)'(cx_q);
    dy  = (COORD_W+1)'(tok_i.y) - (COORD_W+1)'(cy_q);
    adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    okx = adx < (COORD_W+1)'(rx_q);
    oky = ady < (COORD_W+1)'(ry_q);
  end

  // (dx*ry)^2 + (dy*rx)^2 < (rx*ry)^2, exact in integers
  assign sum        = (4*RAD_W+1)'(s3_a2_q) + (4*RAD_W+1)'(s3_b2_q);
  assign in_ellipse = s3_live_q && (sum < (4*RAD_W+1)'(s3_c2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      s1_live_q <= 1'b0;
      s2_live_q <= 1'b0;
      s3_live_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (adv_i) begin
      tok_q     <= tok_i;
      s1_live_q <= tok_i.vld && (tok_i.evt == FUNC_EVENT) && active && okx && oky;
      s2_live_q <= s1_live_q;
      s3_live_q <= s2_live_q;
      hit_q     <= hit_i || in_ellipse;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_adx_q   <= adx[RAD_W-1:0];
      s1_ady_q   <= ady[RAD_W-1:0];
      s1_rx_q    <= rx_q;
      s1_ry_q    <= ry_q;
      s2_a_q     <= s1_adx_q * s1_ry_q;
      s2_b_q     <= s1_ady_q * s1_rx_q;
      s2_c_q     <= s1_rx_q * s1_ry_q;
      s3_a2_q    <= s2_a_q * s2_a_q;
      s3_b2_q    <= s2_b_q * s2_b_q;
      s3_c2_q    <= s2_c_q * s2_c_q;
      if (ld_hit) begin
        cx_q <= tok_i.x;
        cy_q <= tok_i.y;
        rx_q <= tok_i.rx;
        ry_q <= tok_i.ry;
      end
    end
  end

  assign tok_o = tok_q;
  assign hit_o = hit_q;

endmodule

// ===== rtl/core/erf_out.sv =====
// ----------------------------------------------------------------------------
// erf_out
// Realigns items leaving the chain with their hit bit and holds the result.
// ----------------------------------------------------------------------------
module erf_out import erf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tail_i,
  input  logic             hit_i,
  input  logic [LOC_W-1:0] flag_mask_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic [LOC_W-1:0] loc_o,
  output logic             hit_o,
  output logic             last_o,
  output logic             adv_o
);

  typedef struct packed {
    logic             vld;
    logic             evt;
    logic [LOC_W-1:0] loc;
    logic             last;
  } meta_t;

  meta_t            dly_q [CELL_LAT];
  meta_t            head;
  logic             take;
  logic             vld_q;
  logic [LOC_W-1:0] loc_q;
  logic             hit_q, last_q;

  assign head  = dly_q[CELL_LAT-1];
  assign take  = head.vld && (head.evt == FUNC_EVENT);
  // the chain only halts when a finished event has nowhere to go
  assign adv_o = !(take && vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELL_LAT; i++) begin
        dly_q[i] <= '0;
      end
      vld_q <= 1'b0;
    end else begin
      if (adv_o) begin
        dly_q[0] <= '{vld: tail_i.vld, evt: tail_i.evt, loc: tail_i.loc,
                      last: tail_i.last};
        for (int i = 1; i < CELL_LAT; i++) begin
          dly_q[i] <= dly_q[i-1];
        end
      end
      if (adv_o && take) begin
        vld_q <= 1'b1;
      end else if (ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && take) begin
      loc_q  <= head.loc | (hit_i ? flag_mask_i : '0);
      hit_q  <= hit_i;
      last_q <= head.last;
    end
  end

  assign valid_o = vld_q;
  assign loc_o   = loc_q;
  assign hit_o   = hit_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/core/elliptical_region_event_flagger_unit.sv =====
// ----------------------------------------------------------------------------
// elliptical_region_event_flagger_unit
// Flags events that fall strictly inside any active (index below region_count) axis-aligned ellipse.
// ----------------------------------------------------------------------------
// Usage:
// evt_i takes two kinds of item. A load item (func low) writes one region
// slot; it gives no result. A classify item (func high) gives exactly one
// result on res_o: location byte, hit bit and the batch-end copy.
// Items run down a chain of 64 cells, one cell per cycle unless halted;
// each cell holds one region and, below region_count, tests every passing
// event in a 3-stage multiply pipeline, ORing its verdict into a hit bit
// that follows the item three cells behind. Loads travel the same chain, so
// item order is kept exactly. One item is taken per cycle unless halted;
// a result is realigned with its hit bit and registered before res_o.
// cfg_we_i writes region_count (index 0) or flag_mask (index 1); write them
// only while no item is in flight.
// Reset clears all control state and the registers to region_count 0 and
// flag_mask 1; region slots hold no value until loaded.
// A result waits in the output register; input is still taken until a
// finished event reaches the end of the chain with the register full, then
// the whole chain holds until res_o is taken.
// ----------------------------------------------------------------------------
module elliptical_region_event_flagger_unit import erf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  erf_evt_if.sink               evt_i,
  erf_res_if.source             res_o
);

  logic [CNT_W-1:0] region_count_q;
  logic [LOC_W-1:0] flag_mask_q;
  logic             adv;
  tok_t             tok [MAX_REGIONS+1];
  logic             hit_chain [MAX_REGIONS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= REGION_COUNT_RST;
      flag_mask_q    <= FLAG_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REGION_COUNT: region_count_q <= cfg_data_i[CNT_W-1:0];
        REG_FLAG_MASK:    flag_mask_q    <= cfg_data_i[LOC_W-1:0];
        default: ;
      endcase
    end
  end

  assign evt_i.ready = adv;

  always_comb begin
    tok[0].vld  = evt_i.valid && adv;
    tok[0].evt  = evt_i.func;
    tok[0].idx  = evt_i.region_index;
    tok[0].x    = (evt_i.func == FUNC_EVENT) ? evt_i.event_x : evt_i.center_x;
    tok[0].y    = (evt_i.func == FUNC_EVENT) ? evt_i.event_y : evt_i.center_y;
    tok[0].rx   = evt_i.radius_x;
    tok[0].ry   = evt_i.radius_y;
    tok[0].loc  = evt_i.location_in;
    tok[0].last = evt_i.last_event;
  end

  assign hit_chain[0] = 1'b0;

  for (genvar j = 0; j < MAX_REGIONS; j++) begin : g_cell
    erf_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (adv),
      .cell_id_i      (IDX_W'(j)),
      .region_count_i (region_count_q),
      .tok_i          (tok[j]),
      .hit_i          (hit_chain[j]),
      .tok_o          (tok[j+1]),
      .hit_o          (hit_chain[j+1])
    );
  end

  erf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tail_i      (tok[MAX_REGIONS]),
    .hit_i       (hit_chain[MAX_REGIONS]),
    .flag_mask_i (flag_mask_q),
    .ready_i     (res_o.ready),
    .valid_o     (res_o.valid),
    .loc_o       (res_o.location_out),
    .hit_o       (res_o.hit),
    .last_o      (res_o.last_out),
    .adv_o       (adv)
  );

  // input is only refused while a result is stuck in the output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input refused without a stalled result");

  // a halted chain keeps its last item in place
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(tok[MAX_REGIONS].vld))
    else $error("chain moved while halted");

  // the hit bit at the chain end holds while halted
  a_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(hit_chain[MAX_REGIONS]))
    else $error("hit chain moved while halted");

endmodule
